### hw/rtl/rhpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhpm_pkg;

   // default window depth
   localparam int MAX_PATTERN_DEFAULT = 16;

   // marker characters
   localparam logic [7:0] OPEN_MARK  = 8'h5B;
   localparam logic [7:0] CLOSE_MARK = 8'h5D;

   // saturation limits
   localparam logic [8:0]  SKIP_MAX  = 9'd511;
   localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

   // register reset values
   localparam logic [4:0] PAT_LEN_RESET = 5'd1;
   localparam logic [7:0] RADIX_RESET   = 8'd10;
   localparam logic [7:0] MODULUS_RESET = 8'd11;

   // modulo unit: dividend bits retired per cycle
   localparam int MOD_DVD_W = 16;
   localparam int MOD_STEP  = 4;

   // register map
   typedef enum logic [2:0] {
      REG_PAT_LO  = 3'd0,
      REG_PAT_HI  = 3'd1,
      REG_PAT_LEN = 3'd2,
      REG_RADIX   = 3'd3,
      REG_MODULUS = 3'd4
   } csr_idx_type;

   // operand select for the shared modulo unit
   typedef enum logic [2:0] {
      MS_PH   = 3'd0,
      MS_LP   = 3'd1,
      MS_GONE = 3'd2,
      MS_SUB  = 3'd3,
      MS_TXT  = 3'd4
   } mod_sel_type;

   typedef struct packed {
      logic        accept;
      logic        prep_init;
      logic        inc_k;
      logic        mod_start;
      mod_sel_type mod_sel;
      logic        check;
      logic        open;
      logic        pat;
      logic        close;
      logic        pos;
      logic        fin;
   } rhpm_cmd_type;

   typedef struct packed {
      logic dirty;
      logic mod_done;
      logic fill_ge_m;
      logic k_zero;
      logic k_last;
      logic j_last;
      logic hit;
      logic has_pos;
      logic pos_last;
      logic out_free;
   } rhpm_sts_type;

   // pattern byte k; bytes past 15 read as zero
   function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [6:0] idx);
      logic [63:0] word;
      begin
         word = (idx[3] == 1'b0) ? lo : hi;
         pat_byte = (idx[6:4] != 3'd0) ? 8'd0 : 8'(word >> {idx[2:0], 3'b000});
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rolling_hash_pattern_marker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Beat
// req_      in         req_valid/stall    text_byte, end_of_line, clear_total
// rsp_      out        rsp_valid/stall    out_byte, line_done, line_matched, total
// csr_      in         csr_valid/ready    index, data (64 bits)
//
// One byte at a time. Each modulo by the configured modulus runs on a shared
// 4-bit-per-cycle unit; a byte takes one modulo while the window is not yet
// full and three after it is (outgoing byte, subtraction, new byte), then one
// step per bracket beat and per window position that is emitted or skipped.
// After reset or any register write the pattern hash and lead power are
// rebuilt, one modulo for the first pattern byte and two for each further one,
// while req_stall is high.
// Reset is synchronous; rsp_stall holds the output beat and stalls emission.

module rolling_hash_pattern_marker_core #(
   parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_line,
   input  wire logic        req_clear_total,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_line_done,
   output logic             rsp_line_matched,
   output logic [15:0]      rsp_total_matches,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import rhpm_pkg::*;

   rhpm_cmd_type cmd;
   rhpm_sts_type sts;

   assign csr_ready = 1'b1;

   rhpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rhpm_dp #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_text_byte     (req_text_byte),
      .req_end_of_line   (req_end_of_line),
      .req_clear_total   (req_clear_total),
      .csr_wr            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_line_done     (rsp_line_done),
      .rsp_line_matched  (rsp_line_matched),
      .rsp_total_matches (rsp_total_matches)
   );

endmodule

`default_nettype wire

### hw/rtl/rhpm_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module rhpm_mod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [7:0]  modulus,
   output logic             done,
   output logic [7:0]       remainder
);
   import rhpm_pkg::*;

   localparam int CYC   = MOD_DVD_W / MOD_STEP;
   localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

   logic [15:0]      dvd_ff, dvd_in;
   logic [7:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [8:0]       step_r;

   // restoring remainder, MOD_STEP dividend bits per cycle
   always_comb begin
      step_r = {1'b0, rem_ff};
      for (int i = 0; i < MOD_STEP; i++) begin
         step_r = {step_r[7:0], dvd_ff[15 - i]};
         if (step_r >= {1'b0, modulus}) begin
            step_r = step_r - {1'b0, modulus};
         end
      end
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = 8'd0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_r[7:0];
         dvd_in = dvd_ff << MOD_STEP;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CYC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/rhpm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rhpm_dp #(
   parameter int MAX_PATTERN = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             req_text_byte,
   input  wire logic                   req_end_of_line,
   input  wire logic                   req_clear_total,
   input  wire logic                   csr_wr,
   input  wire logic [2:0]             csr_index,
   input  wire logic [63:0]            csr_data,
   input  wire rhpm_pkg::rhpm_cmd_type cmd,
   output rhpm_pkg::rhpm_sts_type      sts,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_line_done,
   output logic                        rsp_line_matched,
   output logic [15:0]                 rsp_total_matches
);
   import rhpm_pkg::*;

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int K_W   = $clog2(MAX_PATTERN + 1);

   // configuration
   logic [63:0] pat_lo_ff, pat_hi_ff;
   logic [4:0]  pat_len_ff;
   logic [7:0]  radix_ff, modulus_ff;
   logic        dirty_ff;

   // line state
   logic [7:0]     window_ff [MAX_PATTERN];
   logic [K_W-1:0] fill_ff;
   logic [7:0]     th_ff, ph_ff, lp_ff, gone_ff, t_ff;
   logic [8:0]     skip_ff;
   logic           matched_ff;
   logic [15:0]    total_ff;
   logic [7:0]     c_ff;
   logic           eol_ff;
   logic [K_W-1:0] k_ff, j_ff;

   // result staging
   logic        pend_valid_ff;
   logic [7:0]  pend_byte_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_done_ff, rsp_matched_ff;
   logic [15:0] rsp_total_ff;

   logic [K_W-1:0] m_eff, m_last;
   logic [7:0]     q_eff;
   logic           fill_ge_m, exact, hit, out_free;
   logic [15:0]    dvd;
   logic           mod_done;
   logic [7:0]     mod_rem;
   logic [7:0]     lead_byte, pat_k, pat_j;
   logic           cand_valid;
   logic [7:0]     cand_byte;
   logic           rsp_load;
   logic [9:0]     skip_sum;

   // effective length and modulus
   always_comb begin
      if (pat_len_ff == 5'd0) begin
         m_eff = K_W'(1);
      end else if (int'(pat_len_ff) > MAX_PATTERN) begin
         m_eff = K_W'(MAX_PATTERN);
      end else begin
         m_eff = K_W'(pat_len_ff);
      end
   end
   assign m_last    = m_eff - 1'b1;
   assign q_eff     = (modulus_ff < 8'd2) ? 8'd2 : modulus_ff;
   assign fill_ge_m = (fill_ff >= m_eff);
   assign lead_byte = window_ff[m_last[IDX_W-1:0]];
   assign pat_k     = pat_byte(pat_lo_ff, pat_hi_ff, 7'(k_ff));
   assign pat_j     = pat_byte(pat_lo_ff, pat_hi_ff, 7'(j_ff));

   // exact compare of the window against the pattern
   always_comb begin
      exact = 1'b1;
      for (int jj = 0; jj < MAX_PATTERN; jj++) begin
         if (jj < int'(m_eff)) begin
            if (window_ff[IDX_W'(int'(m_last) - jj)] !=
                pat_byte(pat_lo_ff, pat_hi_ff, 7'(jj))) begin
               exact = 1'b0;
            end
         end
      end
   end
   assign hit = fill_ge_m && (th_ff == ph_ff) && exact;

   // modulo operand select
   always_comb begin
      case (cmd.mod_sel)
         MS_PH:   dvd = 16'(ph_ff) * 16'(radix_ff) + 16'(pat_k);
         MS_LP:   dvd = 16'(lp_ff) * 16'(radix_ff);
         MS_GONE: dvd = 16'(lead_byte) * 16'(lp_ff);
         MS_SUB:  dvd = 16'(th_ff) + 16'(q_eff) - 16'(gone_ff);
         MS_TXT:  dvd = 16'(t_ff) * 16'(radix_ff) + 16'(c_ff);
         default: dvd = 16'd0;
      endcase
   end

   rhpm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (dvd),
      .modulus   (q_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // candidate result of this cycle
   always_comb begin
      cand_valid = 1'b0;
      cand_byte  = OPEN_MARK;
      if (cmd.open) begin
         cand_valid = 1'b1;
      end else if (cmd.pat) begin
         cand_valid = 1'b1;
         cand_byte  = pat_j;
      end else if (cmd.close) begin
         cand_valid = 1'b1;
         cand_byte  = CLOSE_MARK;
      end else if (cmd.pos && (skip_ff == 9'd0)) begin
         cand_valid = 1'b1;
         cand_byte  = window_ff[k_ff[IDX_W-1:0]];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = pend_valid_ff && (cand_valid || cmd.fin);
   assign skip_sum = 10'(skip_ff) + 10'(m_eff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= PAT_LEN_RESET;
         radix_ff   <= RADIX_RESET;
         modulus_ff <= MODULUS_RESET;
         dirty_ff   <= 1'b1;
      end else begin
         if (csr_wr) begin
            case (csr_idx_type'(csr_index))
               REG_PAT_LO:  pat_lo_ff  <= csr_data;
               REG_PAT_HI:  pat_hi_ff  <= csr_data;
               REG_PAT_LEN: pat_len_ff <= csr_data[4:0];
               REG_RADIX:   radix_ff   <= csr_data[7:0];
               REG_MODULUS: modulus_ff <= csr_data[7:0];
               default:     ;
            endcase
         end
         if (csr_wr) begin
            dirty_ff <= 1'b1;
         end else if (cmd.prep_init) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // hash, window fill and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         th_ff      <= 8'd0;
         skip_ff    <= 9'd0;
         matched_ff <= 1'b0;
         total_ff   <= 16'd0;
      end else begin
         if (cmd.accept && req_clear_total) begin
            total_ff <= 16'd0;
         end
         if (mod_done && (cmd.mod_sel == MS_TXT)) begin
            th_ff <= mod_rem;
            if (int'(fill_ff) < MAX_PATTERN) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd.check && hit) begin
            matched_ff <= 1'b1;
            if (total_ff != TOTAL_MAX) begin
               total_ff <= total_ff + 16'd1;
            end
         end
         if (cmd.close) begin
            skip_ff <= (skip_sum > 10'(SKIP_MAX)) ? SKIP_MAX : skip_sum[8:0];
         end
         if (cmd.pos && (skip_ff != 9'd0)) begin
            skip_ff <= skip_ff - 9'd1;
         end
         if (cmd.fin && eol_ff) begin
            fill_ff    <= '0;
            th_ff      <= 8'd0;
            skip_ff    <= 9'd0;
            matched_ff <= 1'b0;
         end
      end
   end

   // datapath payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         c_ff   <= req_text_byte;
         eol_ff <= req_end_of_line;
         t_ff   <= th_ff;
      end
      if (cmd.prep_init) begin
         ph_ff <= 8'd0;
         lp_ff <= 8'd1;
         k_ff  <= '0;
      end
      if (cmd.inc_k) begin
         k_ff <= k_ff + 1'b1;
      end
      if (mod_done) begin
         case (cmd.mod_sel)
            MS_PH:   ph_ff   <= mod_rem;
            MS_LP:   lp_ff   <= mod_rem;
            MS_GONE: gone_ff <= mod_rem;
            MS_SUB:  t_ff    <= mod_rem;
            MS_TXT: begin
               for (int i = MAX_PATTERN - 1; i > 0; i--) begin
                  window_ff[i] <= window_ff[i - 1];
               end
               window_ff[0] <= c_ff;
            end
            default: ;
         endcase
      end
      if (cmd.check) begin
         k_ff <= fill_ge_m ? m_last : fill_ff - 1'b1;
      end
      if (cmd.open) begin
         j_ff <= '0;
      end
      if (cmd.pat) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.pos && (k_ff != '0)) begin
         k_ff <= k_ff - 1'b1;
      end
   end

   // one result held back so the last of a line can be flagged
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cand_valid) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.fin) begin
            pend_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_load | (rsp_valid_ff & rsp_stall);
      end
      if (cand_valid) begin
         pend_byte_ff <= cand_byte;
      end
      if (rsp_load) begin
         rsp_byte_ff    <= pend_byte_ff;
         rsp_done_ff    <= cmd.fin && eol_ff;
         rsp_matched_ff <= cmd.fin && eol_ff && matched_ff;
         rsp_total_ff   <= total_ff;
      end
   end

   always_comb begin
      sts.dirty     = dirty_ff;
      sts.mod_done  = mod_done;
      sts.fill_ge_m = fill_ge_m;
      sts.k_zero    = (k_ff == '0);
      sts.k_last    = (k_ff == m_last);
      sts.j_last    = (j_ff == m_last);
      sts.hit       = hit;
      sts.has_pos   = fill_ge_m || eol_ff;
      sts.pos_last  = !eol_ff || (k_ff == '0);
      sts.out_free  = out_free;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_line_done     = rsp_done_ff;
   assign rsp_line_matched  = rsp_matched_ff;
   assign rsp_total_matches = rsp_total_ff;

`ifndef SYNTHESIS
   // a beat never overwrites one that is still waiting
   a_load_free : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten");

   // each item flushes its held result before the next is taken
   a_accept_empty : assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !pend_valid_ff)
      else $error("held result left over at accept");

   // line end clears the window fill
   a_line_clear : assert property (@(posedge clock) disable iff (reset)
      (cmd.fin && eol_ff) |=> (fill_ff == '0))
      else $error("window not cleared at line end");
`endif

endmodule

`default_nettype wire

### hw/rtl/rhpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rhpm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rhpm_pkg::rhpm_sts_type sts,
   output rhpm_pkg::rhpm_cmd_type      cmd
);
   import rhpm_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE      = 17'b00000000000000001,
      ST_PH_GO     = 17'b00000000000000010,
      ST_PH_WAIT   = 17'b00000000000000100,
      ST_LP_GO     = 17'b00000000000001000,
      ST_LP_WAIT   = 17'b00000000000010000,
      ST_ROLL_GO   = 17'b00000000000100000,
      ST_ROLL_WAIT = 17'b00000000001000000,
      ST_SUB_GO    = 17'b00000000010000000,
      ST_SUB_WAIT  = 17'b00000000100000000,
      ST_TXT_GO    = 17'b00000001000000000,
      ST_TXT_WAIT  = 17'b00000010000000000,
      ST_CHECK     = 17'b00000100000000000,
      ST_OPEN      = 17'b00001000000000000,
      ST_PAT       = 17'b00010000000000000,
      ST_CLOSE     = 17'b00100000000000000,
      ST_POS       = 17'b01000000000000000,
      ST_FIN       = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = !((state_ff == ST_IDLE) && !sts.dirty);
   assign accept    = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mod_sel = MS_PH;
      case (state_ff)
         ST_IDLE: begin
            if (sts.dirty) begin
               cmd.prep_init = 1'b1;
               state_in      = ST_PH_GO;
            end else if (accept) begin
               cmd.accept = 1'b1;
               state_in   = sts.fill_ge_m ? ST_ROLL_GO : ST_TXT_GO;
            end
         end
         ST_PH_GO: begin
            cmd.mod_start = 1'b1;
            state_in      = ST_PH_WAIT;
         end
         ST_PH_WAIT: begin
            if (sts.mod_done) begin
               if (!sts.k_zero) begin
                  state_in = ST_LP_GO;
               end else if (sts.k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.inc_k = 1'b1;
                  state_in  = ST_PH_GO;
               end
            end
         end
         ST_LP_GO: begin
            cmd.mod_sel   = MS_LP;
            cmd.mod_start = 1'b1;
            state_in      = ST_LP_WAIT;
         end
         ST_LP_WAIT: begin
            cmd.mod_sel = MS_LP;
            if (sts.mod_done) begin
               if (sts.k_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.inc_k = 1'b1;
                  state_in  = ST_PH_GO;
               end
            end
         end
         ST_ROLL_GO: begin
            cmd.mod_sel   = MS_GONE;
            cmd.mod_start = 1'b1;
            state_in      = ST_ROLL_WAIT;
         end
         ST_ROLL_WAIT: begin
            cmd.mod_sel = MS_GONE;
            if (sts.mod_done) begin
               state_in = ST_SUB_GO;
            end
         end
         ST_SUB_GO: begin
            cmd.mod_sel   = MS_SUB;
            cmd.mod_start = 1'b1;
            state_in      = ST_SUB_WAIT;
         end
         ST_SUB_WAIT: begin
            cmd.mod_sel = MS_SUB;
            if (sts.mod_done) begin
               state_in = ST_TXT_GO;
            end
         end
         ST_TXT_GO: begin
            cmd.mod_sel   = MS_TXT;
            cmd.mod_start = 1'b1;
            state_in      = ST_TXT_WAIT;
         end
         ST_TXT_WAIT: begin
            cmd.mod_sel = MS_TXT;
            if (sts.mod_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.hit) begin
               state_in = ST_OPEN;
            end else if (sts.has_pos) begin
               state_in = ST_POS;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_OPEN: begin
            if (sts.out_free) begin
               cmd.open = 1'b1;
               state_in = ST_PAT;
            end
         end
         ST_PAT: begin
            if (sts.out_free) begin
               cmd.pat = 1'b1;
               if (sts.j_last) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (sts.out_free) begin
               cmd.close = 1'b1;
               state_in  = ST_POS;
            end
         end
         ST_POS: begin
            if (sts.out_free) begin
               cmd.pos = 1'b1;
               if (sts.pos_last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rhpm_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_line;
      logic       clear_total;
   } text_beat_t;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        line_done;
      logic        line_matched;
      logic [15:0] total_matches;
   } mark_beat_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'd0;
   logic        req_end_of_line = 1'b0;
   logic        req_clear_total = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_line_done;
   logic        rsp_line_matched;
   logic [15:0] rsp_total_matches;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [63:0] csr_data = 64'd0;

   rolling_hash_pattern_marker_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_text_byte(req_text_byte), .req_end_of_line(req_end_of_line),
      .req_clear_total(req_clear_total),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte), .rsp_line_done(rsp_line_done),
      .rsp_line_matched(rsp_line_matched), .rsp_total_matches(rsp_total_matches),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow configuration and marker state
   logic [63:0] pat_lo, pat_hi;
   logic [4:0]  pat_len;
   logic [7:0]  radix, modulus;
   logic [7:0]  win [16];
   int unsigned win_fill, txt_hash, skip_left, line_hit, hit_total;

   text_beat_t pending_text[$];
   mark_beat_t marked_line[$];
   int         mismatches = 0;

   task automatic report(input string what);
      $display("MISMATCH %s at %0t", what, $time);
      mismatches++;
   endtask

   function automatic int unsigned pchar(input int unsigned k);
      if (k < 8) return 32'((pat_lo >> (8 * k)) & 64'hFF);
      if (k < 16) return 32'((pat_hi >> (8 * (k - 8))) & 64'hFF);
      return 0;
   endfunction

   function automatic void push_mark(input int unsigned b);
      mark_beat_t r;
      r.out_byte = b[7:0];
      r.line_done = 1'b0;
      r.line_matched = 1'b0;
      r.total_matches = hit_total[15:0];
      marked_line.push_back(r);
   endfunction

   function automatic void place_byte(input int unsigned b);
      if (skip_left == 0) push_mark(b);
      else skip_left--;
   endfunction

   // expected marked beats for one text beat
   function automatic void mark_text(input text_beat_t t);
      int unsigned m, d, q, lp, ph, gone, held, k, first;
      bit hit;
      first = marked_line.size();
      m = pat_len; d = radix; q = modulus;
      if (t.clear_total) hit_total = 0;
      if (m < 1) m = 1;
      if (m > 16) m = 16;
      if (q < 2) q = 2;
      lp = 1 % q;
      for (k = 1; k < m; k++) lp = (lp * d) % q;
      ph = 0;
      for (k = 0; k < m; k++) ph = (ph * d + pchar(k)) % q;
      if (win_fill >= m) begin
         gone = (win[m-1] * lp) % q;
         txt_hash = ((((txt_hash + q - gone) % q) * d) + t.text_byte) % q;
      end else begin
         txt_hash = (txt_hash * d + t.text_byte) % q;
      end
      for (k = 15; k > 0; k--) win[k] = win[k-1];
      win[0] = t.text_byte;
      if (win_fill < 16) win_fill++;
      if (win_fill >= m) begin
         hit = (txt_hash == ph);
         for (k = 0; hit && k < m; k++)
            if (win[m-1-k] != pchar(k)) hit = 0;
         if (hit) begin
            if (hit_total < 65535) hit_total++;
            line_hit = 1;
            push_mark(OPEN_MARK);
            for (k = 0; k < m; k++) push_mark(pchar(k));
            push_mark(CLOSE_MARK);
            skip_left += m;
            if (skip_left > 511) skip_left = 511;
         end
         place_byte(win[m-1]);
      end
      if (t.end_of_line) begin
         held = (win_fill >= m) ? m - 1 : win_fill;
         for (k = held; k > 0; k--) place_byte(win[k-1]);
         if (marked_line.size() > first) begin
            marked_line[$].line_done = 1'b1;
            marked_line[$].line_matched = line_hit[0];
         end
         for (k = 0; k < 16; k++) win[k] = 8'd0;
         win_fill = 0; txt_hash = 0; skip_left = 0; line_hit = 0;
      end
   endfunction

   // input monitor: predict the beats of each text beat at its accepting edge
   bit req_taken = 1'b0;
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         mark_text({req_text_byte, req_end_of_line, req_clear_total});
         req_taken = 1'b1;
      end
   end

   // driver: one text beat from the pending queue, random gaps
   int unsigned req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_valid <= 1'b0;
            req_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
         end else if (!req_valid && pending_text.size() > 0) begin
            if (req_gap > 0) req_gap--;
            else begin
               {req_text_byte, req_end_of_line, req_clear_total} <= pending_text.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // rsp stall pattern, stretches without stall
   int unsigned stall_left = 0;
   bit          stall_mode = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 60) == 0) stall_mode = !stall_mode;
         if (stall_mode && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_stall <= (stall_left > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: compare every accepted beat with the oldest expected one
   always @(posedge clock) begin
      mark_beat_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (marked_line.size() == 0) report("unexpected beat");
         else begin
            want = marked_line.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report($sformatf("out_byte %h want %h", rsp_out_byte, want.out_byte));
            if (rsp_line_done !== want.line_done)
               report($sformatf("line_done %b want %b", rsp_line_done, want.line_done));
            if (rsp_line_matched !== want.line_matched)
               report($sformatf("line_matched %b want %b", rsp_line_matched,
                                want.line_matched));
            if (rsp_total_matches !== want.total_matches)
               report($sformatf("total %0d want %0d", rsp_total_matches,
                                want.total_matches));
         end
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_PAT_LO:  pat_lo = val;
         REG_PAT_HI:  pat_hi = val;
         REG_PAT_LEN: pat_len = val[4:0];
         REG_RADIX:   radix = val[7:0];
         REG_MODULUS: modulus = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_text.size() > 0 || req_valid || marked_line.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_pattern(input int unsigned m, input logic [7:0] d,
                              input logic [7:0] q, input logic [127:0] bytes);
      write_reg(REG_PAT_LO, bytes[63:0]);
      write_reg(REG_PAT_HI, bytes[127:64]);
      write_reg(REG_PAT_LEN, 64'(m));
      write_reg(REG_RADIX, 64'(d));
      write_reg(REG_MODULUS, 64'(q));
   endtask

   function automatic logic [7:0] pick_char(input int unsigned m);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return 8'(pchar($urandom_range(0, m - 1)));
      if (r < 9) return 8'($urandom_range(0, 255));
      return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
   endfunction

   // a line mixing pattern copies, overlaps and noise
   task automatic queue_line(input int unsigned m, input int unsigned len);
      text_beat_t t;
      int unsigned k, n;
      n = 0;
      while (n < len) begin
         if ($urandom_range(0, 2) == 0 && n + m <= len) begin
            for (k = 0; k < m; k++) begin
               t.text_byte = 8'(pchar(k));
               t.end_of_line = (n == len - 1);
               t.clear_total = ($urandom_range(0, 40) == 0);
               pending_text.push_back(t);
               n++;
            end
         end else begin
            t.text_byte = pick_char(m);
            t.end_of_line = (n == len - 1);
            t.clear_total = ($urandom_range(0, 40) == 0);
            pending_text.push_back(t);
            n++;
         end
      end
   endtask

   initial begin
      text_beat_t t;
      int unsigned m, sent, ph;
      logic [127:0] pb;
      logic [39:0]  word5;
      pat_lo = 0; pat_hi = 0; pat_len = PAT_LEN_RESET;
      radix = RADIX_RESET; modulus = MODULUS_RESET;
      for (int i = 0; i < 16; i++) win[i] = 8'd0;
      win_fill = 0; txt_hash = 0; skip_left = 0; line_hit = 0; hit_total = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: pattern is a single zero byte
      t = '{8'h00, 1'b0, 1'b0}; pending_text.push_back(t);
      t = '{8'hFF, 1'b0, 1'b1}; pending_text.push_back(t);
      t = '{8'h00, 1'b1, 1'b0}; pending_text.push_back(t);
      drain();

      // "aa" pattern: overlaps, short line, clear total
      set_pattern(2, 8'd1, 8'd255, 128'h6161);
      word5 = "aaaab";
      for (int i = 0; i < 5; i++) begin
         t = '{word5[8 * (4 - i) +: 8], (i == 4), 1'b0};
         pending_text.push_back(t);
      end
      t = '{8'h61, 1'b1, 1'b0}; pending_text.push_back(t);
      t = '{8'h61, 1'b0, 1'b1}; pending_text.push_back(t);
      t = '{8'h61, 1'b1, 1'b0}; pending_text.push_back(t);
      drain();

      // longest pattern, extreme radix and modulus, raw length above range
      set_pattern(16, 8'd255, 8'd2, {16{8'h55}} ^ 128'h00FF_00FF_8000_0001_0203_0405_0607);
      queue_line(16, 34);
      queue_line(16, 5);
      drain();
      set_pattern(0, 8'd0, 8'd0, 128'hFFEE);
      queue_line(1, 6);
      drain();
      write_reg(REG_PAT_LEN, 64'd31);
      queue_line(16, 20);
      drain();

      // random phases, mostly short patterns
      sent = 0;
      while (sent < 180) begin
         m = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4);
         pb = {$urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(0, 1)) pb = pb & {16{8'h03}} | {16{8'h40}};
         set_pattern(m, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pb);
         for (int l = 0; l < 4; l++) begin
            ph = $urandom_range(1, m + 12);
            queue_line(m, ph);
            sent += ph;
         end
         drain();
      end
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
